// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; defining NO_ASSERTIONS compiles them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// a in this cycle implies b in the same cycle
`define ASSERT_SAME(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("same-cycle check failed");

// a in this cycle implies b in the next cycle
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("next-cycle check failed");

`else

`define ASSERT_SAME(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)

`endif

`endif

// ----- sv/sdww_pkg.sv -----
// ----------------------------------------------------------------------------
// sdww_pkg
// Types, panel constants and command codes of the display window writer.
// ----------------------------------------------------------------------------
`default_nettype none

package sdww_pkg;

  localparam int PANEL_WIDTH  = 240;
  localparam int PANEL_HEIGHT = 320;

  // width that holds either panel dimension itself
  localparam int DIM_MAX = (PANEL_WIDTH > PANEL_HEIGHT) ? PANEL_WIDTH : PANEL_HEIGHT;
  localparam int DIM_W   = $clog2(DIM_MAX + 1);

  localparam int ADDR_W  = 17;
  localparam int PIX_W   = 16;
  localparam int COORD_W = 16;
  localparam int CUR_W   = 17;
  localparam int PROD_W  = 2 * DIM_W + 1;
  localparam int SUM_W   = (PROD_W > ADDR_W) ? PROD_W : ADDR_W;

  // command codes
  localparam logic [7:0] CMD_COLSET = 8'h2A;
  localparam logic [7:0] CMD_ROWSET = 8'h2B;
  localparam logic [7:0] CMD_MEMWR  = 8'h2C;
  localparam logic [7:0] CMD_ACCESS = 8'h36;

  // access-control bit that swaps width and height
  localparam int SWAP_BIT = 5;

  // item kinds
  localparam logic REQ_LEVEL = 1'b0;
  localparam logic REQ_BYTE  = 1'b1;

  // window parameter bytes per command
  localparam logic [2:0] WIN_BYTES = 3'd4;

  typedef struct packed {
    logic       req_type;
    logic       dc_level;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] pixel_addr;
    logic [PIX_W-1:0]  pixel_value;
  } out_item_t;

  typedef struct packed {
    logic             valid;
    out_item_t        item;
  } result_t;

  typedef struct packed {
    logic             swap;
    logic [CUR_W-1:0] cursor_row;
    logic [CUR_W-1:0] cursor_col;
  } addr_req_t;

  typedef struct packed {
    logic              in_range;
    logic [ADDR_W-1:0] addr;
  } addr_rsp_t;

  function automatic logic [DIM_W-1:0] eff_width(input logic swap);
    return swap ? DIM_W'(PANEL_HEIGHT) : DIM_W'(PANEL_WIDTH);
  endfunction

  function automatic logic [DIM_W-1:0] eff_height(input logic swap);
    return swap ? DIM_W'(PANEL_WIDTH) : DIM_W'(PANEL_HEIGHT);
  endfunction

endpackage

`default_nettype wire

// ----- sv/sdww_in_if.sv -----
// ----------------------------------------------------------------------------
// sdww_in_if
// Byte channel: data/command line changes and SPI byte transfers.
// ----------------------------------------------------------------------------
`default_nettype none

interface sdww_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic       dc_level;
  logic [7:0] data_byte;

  modport source (output valid, output req_type, output dc_level, output data_byte,
                  input ready);
  modport sink   (input valid, input req_type, input dc_level, input data_byte,
                  output ready);
endinterface

`default_nettype wire

// ----- sv/sdww_out_if.sv -----
// ----------------------------------------------------------------------------
// sdww_out_if
// Pixel channel: framebuffer word writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface sdww_out_if;
  logic                         valid;
  logic                         ready;
  logic [sdww_pkg::ADDR_W-1:0]  pixel_addr;
  logic [sdww_pkg::PIX_W-1:0]   pixel_value;

  modport source (output valid, output pixel_addr, output pixel_value, input ready);
  modport sink   (input valid, input pixel_addr, input pixel_value, output ready);
endinterface

`default_nettype wire

// ----- sv/sdww_addr.sv -----
// ----------------------------------------------------------------------------
// sdww_addr
// Range check of the cursor and row * width + column address.
// ----------------------------------------------------------------------------
`default_nettype none

module sdww_addr (
  input  sdww_pkg::addr_req_t req,
  output sdww_pkg::addr_rsp_t rsp
);

  logic [sdww_pkg::DIM_W-1:0]  w;
  logic [sdww_pkg::DIM_W-1:0]  h;
  logic [sdww_pkg::PROD_W-1:0] prod;
  logic [sdww_pkg::SUM_W-1:0]  sum;

  // pick effective dimensions
  assign w = sdww_pkg::eff_width(req.swap);
  assign h = sdww_pkg::eff_height(req.swap);

  // cursor inside the effective panel
  assign rsp.in_range = (req.cursor_row < sdww_pkg::CUR_W'(h)) &&
                        (req.cursor_col < sdww_pkg::CUR_W'(w));

  // only low DIM_W bits matter when in range
  assign prod = sdww_pkg::PROD_W'(req.cursor_row[sdww_pkg::DIM_W-1:0]) *
                sdww_pkg::PROD_W'(w);
  assign sum  = sdww_pkg::SUM_W'(prod) +
                sdww_pkg::SUM_W'(req.cursor_col[sdww_pkg::DIM_W-1:0]);
  assign rsp.addr = sum[sdww_pkg::ADDR_W-1:0];

endmodule

`default_nettype wire

// ----- sv/sdww_ctrl.sv -----
// ----------------------------------------------------------------------------
// sdww_ctrl
// Command decode, window registers, pixel assembly and cursor advance.
// ----------------------------------------------------------------------------
`default_nettype none

module sdww_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 advance,
  input  sdww_pkg::in_item_t  item,
  output sdww_pkg::result_t   res
);

  localparam int CW = sdww_pkg::COORD_W;
  localparam int KW = sdww_pkg::CUR_W;

  logic                    dc_line, dc_line_next;
  logic [7:0]              current_command, current_command_next;
  logic [2:0]              param_count, param_count_next;
  logic [7:0]              param_bytes [3];
  logic [7:0]              param_bytes_next [3];
  logic                    pixel_phase_high, pixel_phase_high_next;
  logic [7:0]              held_high_byte, held_high_byte_next;
  logic [CW-1:0]           col_first, col_first_next;
  logic [CW-1:0]           col_last, col_last_next;
  logic [CW-1:0]           row_first, row_first_next;
  logic [CW-1:0]           row_last, row_last_next;
  logic [KW-1:0]           cursor_col, cursor_col_next;
  logic [KW-1:0]           cursor_row, cursor_row_next;
  logic [7:0]              access_control, access_control_next;

  logic                    swap;
  logic [CW-1:0]           win_lo;
  logic [CW-1:0]           win_hi;
  logic [CW-1:0]           col_lim;
  logic [CW-1:0]           row_lim;
  logic [KW-1:0]           col_inc;
  logic [KW-1:0]           row_inc;
  logic                    win_done;
  logic                    pixel_done;
  sdww_pkg::addr_req_t     areq;
  sdww_pkg::addr_rsp_t     arsp;

  assign swap    = access_control[sdww_pkg::SWAP_BIT];
  assign col_lim = CW'(sdww_pkg::eff_width(swap));
  assign row_lim = CW'(sdww_pkg::eff_height(swap));
  assign win_lo  = {param_bytes[0], param_bytes[1]};
  assign win_hi  = {param_bytes[2], item.data_byte};
  assign col_inc = cursor_col + KW'(1);
  assign row_inc = cursor_row + KW'(1);

  assign areq.swap       = swap;
  assign areq.cursor_row = cursor_row;
  assign areq.cursor_col = cursor_col;

  sdww_addr u_addr (
    .req (areq),
    .rsp (arsp)
  );

  // next state for one item
  always_comb begin
    dc_line_next          = dc_line;
    current_command_next  = current_command;
    param_count_next      = param_count;
    param_bytes_next      = param_bytes;
    pixel_phase_high_next = pixel_phase_high;
    held_high_byte_next   = held_high_byte;
    col_first_next        = col_first;
    col_last_next         = col_last;
    row_first_next        = row_first;
    row_last_next         = row_last;
    cursor_col_next       = cursor_col;
    cursor_row_next       = cursor_row;
    access_control_next   = access_control;
    win_done              = 1'b0;
    pixel_done            = 1'b0;

    if (item.req_type == sdww_pkg::REQ_LEVEL) begin
      dc_line_next = item.dc_level;
      if (!item.dc_level) begin
        param_count_next      = '0;
        pixel_phase_high_next = 1'b1;
      end
    end else if (!dc_line) begin
      current_command_next  = item.data_byte;
      param_count_next      = '0;
      pixel_phase_high_next = 1'b1;
    end else begin
      unique case (current_command)
        sdww_pkg::CMD_COLSET, sdww_pkg::CMD_ROWSET: begin
          // gather window bytes, ignore any past the fourth
          if (param_count < sdww_pkg::WIN_BYTES) begin
            if (param_count < sdww_pkg::WIN_BYTES - 3'd1) begin
              param_bytes_next[param_count[1:0]] = item.data_byte;
            end
            param_count_next = param_count + 3'd1;
            win_done = (param_count == sdww_pkg::WIN_BYTES - 3'd1);
          end
          if (win_done && current_command == sdww_pkg::CMD_COLSET) begin
            col_first_next  = win_lo;
            col_last_next   = (win_hi >= col_lim) ? col_lim - CW'(1) : win_hi;
            cursor_col_next = KW'(win_lo);
          end else if (win_done) begin
            row_first_next  = win_lo;
            row_last_next   = (win_hi >= row_lim) ? row_lim - CW'(1) : win_hi;
            cursor_row_next = KW'(win_lo);
          end
        end
        sdww_pkg::CMD_MEMWR: begin
          if (pixel_phase_high) begin
            held_high_byte_next   = item.data_byte;
            pixel_phase_high_next = 1'b0;
          end else begin
            pixel_phase_high_next = 1'b1;
            pixel_done            = 1'b1;
            // advance cursor, wrap within the window
            if (col_inc > KW'(col_last)) begin
              cursor_col_next = KW'(col_first);
              cursor_row_next = (row_inc > KW'(row_last)) ? KW'(row_first) : row_inc;
            end else begin
              cursor_col_next = col_inc;
            end
          end
        end
        sdww_pkg::CMD_ACCESS: begin
          access_control_next = item.data_byte;
        end
        default: begin
        end
      endcase
    end
  end

  // result for the item in flight
  assign res.valid            = pixel_done && arsp.in_range;
  assign res.item.pixel_addr  = arsp.addr;
  assign res.item.pixel_value = {held_high_byte, item.data_byte};

  // hold state, update once per processed item
  always_ff @(posedge clk) begin
    if (rst) begin
      dc_line          <= 1'b0;
      current_command  <= '0;
      param_count      <= '0;
      param_bytes      <= '{default: '0};
      pixel_phase_high <= 1'b0;
      held_high_byte   <= '0;
      col_first        <= '0;
      col_last         <= CW'(sdww_pkg::PANEL_WIDTH - 1);
      row_first        <= '0;
      row_last         <= CW'(sdww_pkg::PANEL_HEIGHT - 1);
      cursor_col       <= '0;
      cursor_row       <= '0;
      access_control   <= '0;
    end else if (advance) begin
      dc_line          <= dc_line_next;
      current_command  <= current_command_next;
      param_count      <= param_count_next;
      param_bytes      <= param_bytes_next;
      pixel_phase_high <= pixel_phase_high_next;
      held_high_byte   <= held_high_byte_next;
      col_first        <= col_first_next;
      col_last         <= col_last_next;
      row_first        <= row_first_next;
      row_last         <= row_last_next;
      cursor_col       <= cursor_col_next;
      cursor_row       <= cursor_row_next;
      access_control   <= access_control_next;
    end
  end

endmodule

`default_nettype wire

// ----- sv/spi_display_window_writer.sv -----
// ----------------------------------------------------------------------------
// spi_display_window_writer
// Display controller window and memory-write path, byte in, pixel write out.
// ----------------------------------------------------------------------------
// The block takes one item per clock while no pixel write is stalled: an
// accepted item is held in the input register, is decoded against the
// window and cursor state, and any framebuffer write it causes is loaded
// into the output register as the item is processed, to be offered from there.
// The sustained rate of one item per cycle rests on the cursor update and the
// row times width multiply-add being combinational.
// While a pixel write waits unaccepted in the output register, the item
// behind it holds in the input register and the byte channel stalls.
`default_nettype none
`include "assert_macros.svh"

module spi_display_window_writer (
  input  wire         clk,
  input  wire         rst,
  sdww_in_if.sink     bytes,
  sdww_out_if.source  pixels
);

  logic                 in_valid_q;
  sdww_pkg::in_item_t   in_q;
  logic                 out_valid_q;
  sdww_pkg::out_item_t  out_q;
  logic                 advance;
  sdww_pkg::result_t    res;

  // process the held item when the output side can take its result
  assign advance     = in_valid_q && (!out_valid_q || pixels.ready);
  assign bytes.ready = !in_valid_q || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (bytes.valid && bytes.ready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.valid && bytes.ready) begin
      in_q.req_type  <= bytes.req_type;
      in_q.dc_level  <= bytes.dc_level;
      in_q.data_byte <= bytes.data_byte;
    end
  end

  sdww_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (in_q),
    .res     (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res.valid;
    end else if (pixels.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      out_q <= res.item;
    end
  end

  assign pixels.valid       = out_valid_q;
  assign pixels.pixel_addr  = out_q.pixel_addr;
  assign pixels.pixel_value = out_q.pixel_value;

  // empty input register always takes an item
  `ASSERT_SAME(a_in_ready_empty, clk, rst, !in_valid_q, bytes.ready)
  // stalled item stays put
  `ASSERT_NEXT(a_in_hold, clk, rst, in_valid_q && !advance, in_valid_q && $stable(in_q))
  // item without a write leaves no pixel behind
  `ASSERT_NEXT(a_no_spurious, clk, rst, advance && !res.valid, !pixels.valid)

endmodule

`default_nettype wire

// ----- verif/tb_spi_display_window_writer.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_spi_display_window_writer
// Self-checking bench for the display window writer. A directed opener and a
// long run of command sequences (column/row windows, memory writes, access
// control, unknown commands and line noise) go in through the byte channel.
// A predictor tracks the window, cursor and pixel assembly and checks every
// framebuffer write, with random idle bursts on both channels.
// ----------------------------------------------------------------------------

module tb_spi_display_window_writer;

  localparam int RANDOM_ITEMS = 1850;
  localparam int TAIL_ITEMS   = 150;      // last items run with no idling
  localparam int DRAIN_CYCLES = 8;        // quiet cycles after the last write is checked
  localparam int LIMIT_NS     = 5_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sdww_in_if  bytes_if ();
  sdww_out_if pixels_if ();

  spi_display_window_writer u_dut (
    .clk    (clk),
    .rst    (rst),
    .bytes  (bytes_if),
    .pixels (pixels_if)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // --------------------------------------------------------------------------
  // Window/cursor predictor state
  // --------------------------------------------------------------------------
  logic        line_data   = 1'b0;
  logic [7:0]  active_cmd  = '0;
  logic [2:0]  win_count   = '0;
  logic [7:0]  win_bytes [3] = '{8'h00, 8'h00, 8'h00};
  logic        expect_high = 1'b0;
  logic [7:0]  high_byte   = '0;
  logic [16:0] col_lo      = '0;
  logic [16:0] col_hi      = 17'(sdww_pkg::PANEL_WIDTH - 1);
  logic [16:0] row_lo      = '0;
  logic [16:0] row_hi      = 17'(sdww_pkg::PANEL_HEIGHT - 1);
  logic [16:0] cur_col     = '0;
  logic [16:0] cur_row     = '0;
  logic [7:0]  access_byte = '0;

  sdww_pkg::in_item_t  pending [$];
  sdww_pkg::out_item_t pixel_writes_due [$];

  int errors          = 0;
  int items_accepted  = 0;
  int writes_checked  = 0;
  int window_loads    = 0;
  int clamped_ends    = 0;
  int offpanel_pixels = 0;
  int swapped_writes  = 0;

  // Update the model for one accepted item; return 1 when it writes a pixel.
  function automatic bit predict_pixel(input sdww_pkg::in_item_t it,
                                       output sdww_pkg::out_item_t px);
    int unsigned w;
    int unsigned h;
    int unsigned lo;
    int unsigned hi;
    bit          hit;
    w   = access_byte[sdww_pkg::SWAP_BIT] ? sdww_pkg::PANEL_HEIGHT : sdww_pkg::PANEL_WIDTH;
    h   = access_byte[sdww_pkg::SWAP_BIT] ? sdww_pkg::PANEL_WIDTH : sdww_pkg::PANEL_HEIGHT;
    hit = 1'b0;
    px  = '0;
    if (it.req_type == sdww_pkg::REQ_LEVEL) begin
      line_data = it.dc_level;
      if (!line_data) begin
        win_count   = '0;
        expect_high = 1'b1;
      end
      return 1'b0;
    end
    // byte with the line low is a command
    if (!line_data) begin
      active_cmd  = it.data_byte;
      win_count   = '0;
      expect_high = 1'b1;
      return 1'b0;
    end
    case (active_cmd)
      sdww_pkg::CMD_COLSET, sdww_pkg::CMD_ROWSET: begin
        // gather four bytes, drop the rest
        if (win_count < sdww_pkg::WIN_BYTES) begin
          if (win_count < 3) win_bytes[win_count] = it.data_byte;
          win_count++;
          if (win_count == sdww_pkg::WIN_BYTES) begin
            lo = {win_bytes[0], win_bytes[1]};
            hi = {win_bytes[2], it.data_byte};
            window_loads++;
            if (active_cmd == sdww_pkg::CMD_COLSET) begin
              if (hi >= w) begin
                hi = w - 1;
                clamped_ends++;
              end
              col_lo  = 17'(lo);
              col_hi  = 17'(hi);
              cur_col = 17'(lo);
            end else begin
              if (hi >= h) begin
                hi = h - 1;
                clamped_ends++;
              end
              row_lo  = 17'(lo);
              row_hi  = 17'(hi);
              cur_row = 17'(lo);
            end
          end
        end
      end
      sdww_pkg::CMD_MEMWR: begin
        if (expect_high) begin
          high_byte   = it.data_byte;
          expect_high = 1'b0;
        end else begin
          expect_high = 1'b1;
          if (cur_row < h && cur_col < w) begin
            hit            = 1'b1;
            px.pixel_addr  = sdww_pkg::ADDR_W'(cur_row * w + cur_col);
            px.pixel_value = {high_byte, it.data_byte};
            if (access_byte[sdww_pkg::SWAP_BIT]) swapped_writes++;
          end else begin
            offpanel_pixels++;
          end
          // advance and wrap within the window
          cur_col = cur_col + 17'd1;
          if (cur_col > col_hi) begin
            cur_col = col_lo;
            cur_row = cur_row + 17'd1;
            if (cur_row > row_hi) cur_row = row_lo;
          end
        end
      end
      sdww_pkg::CMD_ACCESS: access_byte = it.data_byte;
      default: ;
    endcase
    return hit;
  endfunction

  // --------------------------------------------------------------------------
  // Sequence builders
  // --------------------------------------------------------------------------
  task automatic push_level(input logic lvl);
    sdww_pkg::in_item_t it;
    it.req_type  = sdww_pkg::REQ_LEVEL;
    it.dc_level  = lvl;
    it.data_byte = 8'($urandom_range(0, 255));
    pending.push_back(it);
  endtask

  task automatic push_byte(input logic [7:0] b);
    sdww_pkg::in_item_t it;
    it.req_type  = sdww_pkg::REQ_BYTE;
    it.dc_level  = 1'($urandom_range(0, 1));
    it.data_byte = b;
    pending.push_back(it);
  endtask

  // line low, command byte, line high
  task automatic push_command(input logic [7:0] cmd);
    push_level(1'b0);
    push_byte(cmd);
    push_level(1'b1);
  endtask

  task automatic push_window(input logic [7:0] cmd, input logic [15:0] lo,
                             input logic [15:0] hi, input int nbytes);
    logic [7:0] seq [4];
    seq = '{lo[15:8], lo[7:0], hi[15:8], hi[7:0]};
    push_command(cmd);
    for (int i = 0; i < nbytes; i++)
      push_byte(i < 4 ? seq[i] : 8'($urandom_range(0, 255)));
  endtask

  function automatic logic [15:0] pick_coord();
    int unsigned span;
    int unsigned r;
    span = $urandom_range(0, 1) ? sdww_pkg::PANEL_WIDTH : sdww_pkg::PANEL_HEIGHT;
    r    = $urandom_range(0, 99);
    if (r < 70) return 16'($urandom_range(0, span - 1));
    if (r < 85) return 16'($urandom_range(span - 3, span + 2));
    return 16'($urandom());
  endfunction

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 5;
      2:       return 20;
      default: return 40;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Driver: feed queued items, idle in random bursts
  // --------------------------------------------------------------------------
  sdww_pkg::in_item_t  sent_item;
  sdww_pkg::out_item_t predicted_px;
  int in_gap      = 0;
  int in_stretch  = 0;
  int in_idle_pct = 0;

  always @(posedge clk) begin
    if (rst) begin
      bytes_if.valid <= 1'b0;
    end else begin
      if (bytes_if.valid && bytes_if.ready) begin
        if (predict_pixel(sent_item, predicted_px)) pixel_writes_due.push_back(predicted_px);
        items_accepted++;
      end
      if (in_stretch == 0) begin
        in_stretch  = $urandom_range(40, 300);
        in_idle_pct = pick_idle_pct();
      end else begin
        in_stretch--;
      end
      // hold a stalled item; otherwise pick the next cycle's drive
      if (!(bytes_if.valid && !bytes_if.ready)) begin
        if (in_gap > 0) begin
          in_gap--;
          bytes_if.valid <= 1'b0;
        end else if (pending.size() == 0) begin
          bytes_if.valid <= 1'b0;
        end else if (pending.size() > TAIL_ITEMS &&
                     $urandom_range(1, 100) <= in_idle_pct) begin
          in_gap = $urandom_range(0, 8);
          bytes_if.valid <= 1'b0;
        end else begin
          sent_item = pending.pop_front();
          bytes_if.valid     <= 1'b1;
          bytes_if.req_type  <= sent_item.req_type;
          bytes_if.dc_level  <= sent_item.dc_level;
          bytes_if.data_byte <= sent_item.data_byte;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check pixel writes in order, stall in random bursts
  // --------------------------------------------------------------------------
  sdww_pkg::out_item_t oldest_px;
  int out_gap      = 0;
  int out_stretch  = 0;
  int out_idle_pct = 0;

  always @(posedge clk) begin
    if (rst) begin
      pixels_if.ready <= 1'b0;
    end else begin
      if (pixels_if.valid && pixels_if.ready) begin
        if (pixel_writes_due.size() == 0) begin
          $display("%0t: unexpected pixel write addr %0d value 0x%04h", $time,
                   pixels_if.pixel_addr, pixels_if.pixel_value);
          errors++;
        end else begin
          oldest_px = pixel_writes_due.pop_front();
          if (pixels_if.pixel_addr !== oldest_px.pixel_addr) begin
            $display("%0t: pixel_addr expected %0d actual %0d", $time,
                     oldest_px.pixel_addr, pixels_if.pixel_addr);
            errors++;
          end
          if (pixels_if.pixel_value !== oldest_px.pixel_value) begin
            $display("%0t: pixel_value expected 0x%04h actual 0x%04h", $time,
                     oldest_px.pixel_value, pixels_if.pixel_value);
            errors++;
          end
          writes_checked++;
        end
      end
      if (out_stretch == 0) begin
        out_stretch  = $urandom_range(40, 300);
        out_idle_pct = pick_idle_pct();
      end else begin
        out_stretch--;
      end
      if (out_gap > 0) begin
        out_gap--;
        pixels_if.ready <= 1'b0;
      end else if (pending.size() > TAIL_ITEMS &&
                   $urandom_range(1, 100) <= out_idle_pct) begin
        out_gap = $urandom_range(0, 8);
        pixels_if.ready <= 1'b0;
      end else begin
        pixels_if.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // --------------------------------------------------------------------------
  int          directed_n;
  int unsigned pick;
  int          npix;
  logic [7:0]  odd_cmd;
  logic [15:0] win_lo;
  logic [15:0] win_hi;

  initial begin
    bytes_if.valid     = 1'b0;
    bytes_if.req_type  = sdww_pkg::REQ_LEVEL;
    bytes_if.dc_level  = 1'b0;
    bytes_if.data_byte = '0;
    pixels_if.ready    = 1'b0;

    // Directed opener. The line is low after reset, so the first byte is a
    // command: swap orientation, then a column window whose end lies before its
    // start, with one surplus byte, then a row window whose end overruns the panel.
    push_byte(sdww_pkg::CMD_ACCESS);
    push_level(1'b1);
    push_byte(8'h20);
    push_command(sdww_pkg::CMD_COLSET);
    push_byte(8'h01);
    push_byte(8'h00);
    push_byte(8'h00);
    push_byte(8'h00);
    push_byte(8'h77);
    push_command(sdww_pkg::CMD_ROWSET);
    push_byte(8'h00);
    push_byte(8'h07);
    push_byte(8'hFF);
    push_byte(8'hFF);
    // two pixels at the extremes of the byte range
    push_command(sdww_pkg::CMD_MEMWR);
    push_byte(8'hFF);
    push_byte(8'h00);
    push_byte(8'h00);
    push_byte(8'hFF);
    // unknown command swallows its data
    push_command(8'h00);
    push_byte(8'hAA);
    directed_n = pending.size();

    // Random sequences, mostly well formed
    while (pending.size() < directed_n + RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 36) begin
        win_lo = pick_coord();
        case ($urandom_range(0, 9))
          0, 1:    win_hi = pick_coord();
          2:       win_hi = win_lo - 16'($urandom_range(1, 5));
          3:       win_hi = 16'($urandom());
          default: win_hi = win_lo + 16'($urandom_range(0, 12));
        endcase
        pick = $urandom_range(0, 99);
        push_window(pick < 50 ? sdww_pkg::CMD_COLSET : sdww_pkg::CMD_ROWSET, win_lo, win_hi,
                    $urandom_range(0, 99) < 85 ? 4 :
                    ($urandom_range(0, 1) ? $urandom_range(5, 7) : $urandom_range(1, 3)));
      end else if (pick < 72) begin
        push_command(sdww_pkg::CMD_MEMWR);
        npix = $urandom_range(1, 24);
        for (int i = 0; i < 2 * npix; i++) push_byte(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 9) == 0) push_byte(8'($urandom_range(0, 255)));
      end else if (pick < 80) begin
        push_command(sdww_pkg::CMD_ACCESS);
        push_byte(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 4) == 0) push_byte(8'($urandom_range(0, 255)));
      end else if (pick < 86) begin
        do odd_cmd = 8'($urandom_range(0, 255));
        while (odd_cmd == sdww_pkg::CMD_COLSET || odd_cmd == sdww_pkg::CMD_ROWSET ||
               odd_cmd == sdww_pkg::CMD_MEMWR || odd_cmd == sdww_pkg::CMD_ACCESS);
        push_command(odd_cmd);
        repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
      end else begin
        // raw noise on the line and the bytes
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 1)) push_level(1'($urandom_range(0, 1)));
          else push_byte(8'($urandom_range(0, 255)));
        end
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // drain: all items sent, all writes seen, then a few quiet cycles
    while (pending.size() != 0 || bytes_if.valid) @(posedge clk);
    while (pixel_writes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d items: %0d window loads (%0d clamped ends), %0d off-panel pixels.",
             items_accepted, window_loads, clamped_ends, offpanel_pixels);
    $display("Checked %0d pixel writes, %0d of them with width and height swapped.",
             writes_checked, swapped_writes);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #LIMIT_NS;
    $display("Timeout with %0d items queued and %0d writes outstanding.",
             pending.size(), pixel_writes_due.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
